// ===== design/des_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// des_pkg
// Shared types, permutation tables, S-boxes and key schedule for the DES pipe.
// -----------------------------------------------------------------------------
package des_pkg;

    localparam int unsigned DES_MAX_ROUNDS = 16;
    localparam int unsigned KEY_GROUP      = 7;
    localparam int unsigned SBOX_OUT       = 4;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] l;
        logic [31:0] r;
    } des_stage_t;

    localparam byte unsigned TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };
    localparam byte unsigned TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };
    localparam byte unsigned TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };
    localparam byte unsigned TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25 };
    localparam byte unsigned TAB_PC1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
        61,53,45,37,29,21,13,5,28,20,12,4 };
    localparam byte unsigned TAB_PC2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32 };
    localparam byte unsigned TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] TAB_S [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    function automatic logic [63:0] des_ip(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++)
        begin
            y[63-i] = x[64-TAB_IP[i]];
        end
        return y;
    endfunction

    function automatic logic [63:0] des_fp(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++)
        begin
            y[63-i] = x[64-TAB_FP[i]];
        end
        return y;
    endfunction

    // Round key idx (from 0); pure wiring of the key bits.
    // Parity bits are left at zero: PC-1 never picks them.
    function automatic logic [47:0] des_round_key(input logic [55:0] k,
                                                  input int unsigned idx);
        logic [63:0]  k64;
        logic [55:0]  cd;
        logic [27:0]  c;
        logic [27:0]  d;
        logic [55:0]  cd2;
        logic [47:0]  sk;
        int unsigned  sh;
        k64 = '0;
        for (int g = 0; g < 8; g++)
        begin
            for (int b = 0; b < KEY_GROUP; b++)
            begin
                k64[63-(g*8+b)] = k[55-(g*KEY_GROUP+b)];
            end
        end
        for (int i = 0; i < 56; i++)
        begin
            cd[55-i] = k64[64-TAB_PC1[i]];
        end
        sh = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (i <= idx)
            begin
                sh = sh + TAB_ROT[i];
            end
        end
        c = cd[55:28];
        d = cd[27:0];
        c = (c << sh) | (c >> (28 - sh));
        d = (d << sh) | (d >> (28 - sh));
        cd2 = {c, d};
        for (int i = 0; i < 48; i++)
        begin
            sk[47-i] = cd2[56-TAB_PC2[i]];
        end
        return sk;
    endfunction

    function automatic logic [31:0] des_feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [5:0]  six;
        logic [31:0] o;
        logic [31:0] p;
        for (int i = 0; i < 48; i++)
        begin
            e[47-i] = r[32-TAB_E[i]];
        end
        e = e ^ k;
        for (int s = 0; s < 8; s++)
        begin
            six = e[47-6*s -: 6];
            o[31-SBOX_OUT*s -: SBOX_OUT] = TAB_S[s][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++)
        begin
            p[31-i] = o[32-TAB_P[i]];
        end
        return p;
    endfunction

endpackage

// ===== design/des_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// des_in_if / des_out_if
// Valid/ready channels carrying the block items in and out.
// -----------------------------------------------------------------------------
interface des_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] data_block;

    modport source (output valid, output op, output data_block, input ready);
    modport sink   (input valid, input op, input data_block, output ready);
endinterface

interface des_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_block;

    modport source (output valid, output result_block, input ready);
    modport sink   (input valid, input result_block, output ready);
endinterface

// ===== design/des_cell.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// des_cell
// One Feistel round with its pipeline register.
// -----------------------------------------------------------------------------
module des_cell
    import des_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [47:0] key_enc,
    input  logic [47:0] key_dec,
    input  des_stage_t  prev,
    output des_stage_t  curr
);

    logic        valid_reg;
    logic        op_reg;
    logic [31:0] l_reg;
    logic [31:0] r_reg;
    logic [31:0] l_next;
    logic [31:0] r_next;
    logic [47:0] rk;

    always_comb
    begin
        rk     = (prev.op == OP_DECRYPT) ? key_dec : key_enc;
        l_next = prev.r;
        r_next = prev.l ^ des_feistel(prev.r, rk);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg <= prev.op;
            l_reg  <= l_next;
            r_reg  <= r_next;
        end
    end

    assign curr = '{valid: valid_reg, op: op_reg, l: l_reg, r: r_reg};

endmodule

// ===== design/des_block_cipher_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// des_block_cipher_top
// DES encrypt/decrypt pipe, one Feistel round per cell.
// -----------------------------------------------------------------------------
// Usage:
//   din  : items {op, data_block}; op selects encrypt or decrypt per item.
//   dout : items {result_block}, one per accepted input item, in order.
//   key_we/key_wdata : load the 56-bit key (no parity bits). Write only while
//          the pipe is empty; the round keys follow from it by wiring.
// Pipeline: one cell per round, each with one register; an item passes the
//   cell registers in order and its result is valid once it reaches the last
//   cell. IP feeds the first cell directly and FP is taken from the last
//   cell's register, which is also the output register.
// Throughput: one item per cycle while the pipe advances; every cell moves its
//   item to the next cell on each cycle the pipe advances.
// Stall: the whole chain advances when the output register is empty or being
//   taken. While the receiver holds off with a result waiting, every cell
//   holds, bubbles included, and din.ready drops.
// Reset: clears all cell valid bits and loads key 0.
// -----------------------------------------------------------------------------
module des_block_cipher_top
    import des_pkg::*;
#(
    parameter int unsigned ROUNDS = DES_MAX_ROUNDS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_we,
    input  logic [55:0] key_wdata,
    des_in_if.sink      din,
    des_out_if.source   dout
);

    // Clamp the round count to the legal range.
    localparam int unsigned NR = (ROUNDS < 1) ? 1 :
                                 ((ROUNDS > DES_MAX_ROUNDS) ? DES_MAX_ROUNDS : ROUNDS);

    logic [55:0] key_reg;
    logic        adv;
    logic [63:0] ip_block;
    des_stage_t  stage [NR+1];
    logic [47:0] rkey  [NR];

    // Hold the key; the user must write it only with the pipe drained, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_we)
        begin
            key_reg <= key_wdata;
        end
    end

    // Advance the chain whenever the last cell can hand off its item.
    assign adv       = !stage[NR].valid || dout.ready;
    assign din.ready = adv;

    assign ip_block = des_ip(din.data_block);
    assign stage[0] = '{valid: din.valid, op: din.op,
                        l: ip_block[63:32], r: ip_block[31:0]};

    genvar gi;
    generate
        for (gi = 0; gi < NR; gi++)
        begin : g_round
            assign rkey[gi] = des_round_key(key_reg, gi);
        end
        // Decrypt walks the key list backward.
        for (gi = 0; gi < NR; gi++)
        begin : g_cell
            des_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .key_enc (rkey[gi]),
                .key_dec (rkey[NR-1-gi]),
                .prev    (stage[gi]),
                .curr    (stage[gi+1])
            );
        end
    endgenerate

    // Drop the last round's swap: FP takes {R, L}.
    assign dout.valid        = stage[NR].valid;
    assign dout.result_block = des_fp({stage[NR].r, stage[NR].l});

endmodule

// ===== design/des_chk.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// des_chk
// Port-level checks on the DES pipe, bound to the top level.
// -----------------------------------------------------------------------------
module des_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_data
);

    // A waiting result stays until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // Input is refused only when the output side is blocked.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output stall");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input refused with output free");

endmodule

bind des_block_cipher_top des_chk u_des_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_data  (dout.result_block)
);
